### sv/cfs_pkg.sv
// ----------------------------------------------------------------------------
// cfs_pkg: shared types, codes and helpers for the calendar field stepper
// Holds the date record, the request codes, field limits and the
// increment and saturate helpers used by the step logic.
// ----------------------------------------------------------------------------
package cfs_pkg;

  // Stream widths, in bits
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 32;

  // Request codes
  localparam logic [1:0] OP_INC     = 2'd0;
  localparam logic [1:0] OP_NEW_DAY = 2'd1;
  localparam logic [1:0] OP_LOAD    = 2'd2;

  // Field selects
  localparam logic [2:0] FLD_YEAR   = 3'd0;
  localparam logic [2:0] FLD_MONTH  = 3'd1;
  localparam logic [2:0] FLD_DAY    = 3'd2;
  localparam logic [2:0] FLD_HOUR   = 3'd3;
  localparam logic [2:0] FLD_MINUTE = 3'd4;

  // Field limits
  localparam logic [7:0] YEAR_MIN   = 8'd0;
  localparam logic [7:0] YEAR_MAX   = 8'd86;
  localparam logic [7:0] MONTH_MIN  = 8'd1;
  localparam logic [7:0] MONTH_MAX  = 8'd12;
  localparam logic [7:0] DAY_MIN    = 8'd1;
  localparam logic [7:0] DAY_MAX    = 8'd31;
  localparam logic [7:0] HOUR_MIN   = 8'd0;
  localparam logic [7:0] HOUR_MAX   = 8'd23;
  localparam logic [7:0] MINUTE_MIN = 8'd0;
  localparam logic [7:0] MINUTE_MAX = 8'd59;

  // Leap years have both low year bits clear
  localparam logic [1:0] LEAP_MASK  = 2'b11;

  // Reset values
  localparam logic [6:0] YEAR_RST   = 7'd17;
  localparam logic [3:0] MONTH_RST  = 4'd1;
  localparam logic [4:0] DAY_RST    = 5'd1;
  localparam logic [4:0] HOUR_RST   = 5'd12;
  localparam logic [5:0] MINUTE_RST = 6'd0;

  typedef struct packed {
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year;
  } date_t;

  typedef struct packed {
    logic [7:0] load_value;
    logic [2:0] field_select;
    logic [1:0] opcode;
  } req_t;

  typedef struct packed {
    logic       carry;
    logic [7:0] value;
  } step_t;

  // Days in a month; out-of-range months count as 31
  function automatic logic [7:0] month_len(logic [3:0] month, logic [6:0] year);
    logic [7:0] len;
    case (month)
      4'd2:    len = ((year[1:0] & LEAP_MASK) == 2'b00) ? 8'd29 : 8'd28;
      4'd4,
      4'd6,
      4'd9,
      4'd11:   len = 8'd30;
      default: len = 8'd31;
    endcase
    return len;
  endfunction

  // Step by one, clamp below the minimum, wrap above the maximum
  function automatic step_t wrap_inc(logic [7:0] cur, logic [7:0] lo, logic [7:0] hi);
    step_t r;
    r.value = cur + 8'd1;
    r.carry = 1'b0;
    if (r.value < lo) begin
      r.value = lo;
    end
    if (r.value > hi) begin
      r.value = lo;
      r.carry = 1'b1;
    end
    return r;
  endfunction

  // Clamp a loaded value into a field's range
  function automatic logic [7:0] sat(logic [7:0] val, logic [7:0] lo, logic [7:0] hi);
    logic [7:0] v;
    v = val;
    if (v < lo) begin
      v = lo;
    end
    if (v > hi) begin
      v = hi;
    end
    return v;
  endfunction

endpackage

### sv/calendar_field_stepper.sv
// ----------------------------------------------------------------------------
// calendar_field_stepper: five-field date and time keeper
// Steps, rolls over or loads year, month, day, hour and minute on request.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the s_axis channel carries an opcode (increment one
//   field, new-day advance with day/month/year carry, or load one field),
//   a field select and a load value. Every request yields one result on
//   m_axis with the full date after the request and the carry flag.
//   A request is registered in the input register when accepted, and its
//   result is registered in the output register once that register is
//   free, so a stalled receiver can hold it back. One request is taken per
//   cycle while s_axis_tready is high; the next request's update depends
//   only on the date registers, which change as each result is registered.
//   Reset sets the date to year 17, month 1, day 1, 12:00 and empties both
//   stages. When the receiver holds m_axis_tready low, the result stays in
//   the output register, one more request waits in the input register,
//   and s_axis_tready drops until the output register drains.
// ----------------------------------------------------------------------------
module calendar_field_stepper (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // opcode[1:0], field_select[4:2], load_value[12:5], zero fill
  input  logic [cfs_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // year_out[6:0], month_out[10:7], day_out[15:11], hour_out[20:16],
  // minute_out[26:21], carry_out[27], zero fill
  output logic [cfs_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
  import cfs_pkg::*;

  logic  in_vld;
  req_t  in_req;
  date_t date;
  date_t date_next;
  logic  carry_next;
  logic  out_free;
  logic  move;
  date_t out_date;
  logic  out_carry;

  // Output register empty or draining this cycle
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign move          = in_vld && out_free;
  assign s_axis_tready = !in_vld || out_free;

  // Hold the accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_req <= s_axis_tdata[12:0];
    end
  end

  cfs_step u_step (
    .cur   (date),
    .req   (in_req),
    .nxt   (date_next),
    .carry (carry_next)
  );

  // Advance the date when the request moves to the output
  always_ff @(posedge clk) begin
    if (rst) begin
      date.year   <= YEAR_RST;
      date.month  <= MONTH_RST;
      date.day    <= DAY_RST;
      date.hour   <= HOUR_RST;
      date.minute <= MINUTE_RST;
    end else if (move) begin
      date <= date_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_date  <= date_next;
      out_carry <= carry_next;
    end
  end

  assign m_axis_tdata = {4'b0, out_carry, out_date};

  // Month never leaves its range
  a_month_range: assert property (@(posedge clk) disable iff (rst)
    (date.month >= 4'd1) && (date.month <= 4'd12))
    else $error("month register out of range");

  // Time and year stay in range, and day stays at or above one
  a_other_range: assert property (@(posedge clk) disable iff (rst)
    (date.year <= 7'd86) && (date.hour <= 5'd23) && (date.minute <= 6'd59) &&
    (date.day >= 5'd1))
    else $error("date register out of range");

  // A waiting result always shows the current date
  a_out_matches: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_date == date))
    else $error("result date differs from date registers");

  // A load never reports carry
  a_load_carry: assert property (@(posedge clk) disable iff (rst)
    (move && (in_req.opcode == OP_LOAD)) |=> !out_carry)
    else $error("carry raised on load");

endmodule

### sv/cfs_step.sv
// ----------------------------------------------------------------------------
// cfs_step: next-date logic for one request
// Works out the new date and carry from the current date and one
// increment, new-day or load request.
// ----------------------------------------------------------------------------
module cfs_step (
  input  cfs_pkg::date_t cur,
  input  cfs_pkg::req_t  req,
  output cfs_pkg::date_t nxt,
  output logic           carry
);
  import cfs_pkg::*;

  step_t year_s;
  step_t month_s;
  step_t day_s;
  step_t hour_s;
  step_t minute_s;
  logic [7:0] day_hi;
  logic [7:0] year_ld;
  logic [7:0] month_ld;
  logic [7:0] day_ld;
  logic [7:0] hour_ld;
  logic [7:0] minute_ld;

  // Step each field on its own; the day limit follows the current month
  always_comb begin
    day_hi    = month_len(cur.month, cur.year);
    year_s    = wrap_inc({1'b0, cur.year}, YEAR_MIN, YEAR_MAX);
    month_s   = wrap_inc({4'b0, cur.month}, MONTH_MIN, MONTH_MAX);
    day_s     = wrap_inc({3'b0, cur.day}, DAY_MIN, day_hi);
    hour_s    = wrap_inc({3'b0, cur.hour}, HOUR_MIN, HOUR_MAX);
    minute_s  = wrap_inc({2'b0, cur.minute}, MINUTE_MIN, MINUTE_MAX);
    year_ld   = sat(req.load_value, YEAR_MIN, YEAR_MAX);
    month_ld  = sat(req.load_value, MONTH_MIN, MONTH_MAX);
    day_ld    = sat(req.load_value, DAY_MIN, DAY_MAX);
    hour_ld   = sat(req.load_value, HOUR_MIN, HOUR_MAX);
    minute_ld = sat(req.load_value, MINUTE_MIN, MINUTE_MAX);
  end

  // Select the update for the request
  always_comb begin
    nxt   = cur;
    carry = 1'b0;
    case (req.opcode)
      OP_INC: begin
        case (req.field_select)
          FLD_YEAR: begin
            nxt.year = year_s.value[6:0];
            carry    = year_s.carry;
          end
          FLD_MONTH: begin
            nxt.month = month_s.value[3:0];
            carry     = month_s.carry;
          end
          FLD_DAY: begin
            nxt.day = day_s.value[4:0];
            carry   = day_s.carry;
          end
          FLD_HOUR: begin
            nxt.hour = hour_s.value[4:0];
            carry    = hour_s.carry;
          end
          FLD_MINUTE: begin
            nxt.minute = minute_s.value[5:0];
            carry      = minute_s.carry;
          end
          default: begin
            carry = 1'b0;
          end
        endcase
      end
      OP_NEW_DAY: begin
        // Ripple day into month into year
        nxt.day = day_s.value[4:0];
        carry   = day_s.carry;
        if (day_s.carry) begin
          nxt.month = month_s.value[3:0];
          carry     = month_s.carry;
          if (month_s.carry) begin
            nxt.year = year_s.value[6:0];
            carry    = year_s.carry;
          end
        end
      end
      OP_LOAD: begin
        case (req.field_select)
          FLD_YEAR:   nxt.year   = year_ld[6:0];
          FLD_MONTH:  nxt.month  = month_ld[3:0];
          FLD_DAY:    nxt.day    = day_ld[4:0];
          FLD_HOUR:   nxt.hour   = hour_ld[4:0];
          FLD_MINUTE: nxt.minute = minute_ld[5:0];
          default:    nxt = cur;
        endcase
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for calendar_field_stepper
// Drives increment, new-day and load requests over the input stream, tracks
// the date in a local calendar model and compares every result field by
// field. Directed edge cases come first, then random traffic with bursts of
// idling on both stream sides, and a calm stretch at the end.
// ----------------------------------------------------------------------------
module testbench;
  import cfs_pkg::*;

  // Opcode and field selects that the block must ignore
  localparam logic [1:0] OP_NONE          = 2'd3;
  localparam logic [2:0] FLD_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] FLD_UNUSED_LAST  = 3'd7;

  localparam int RANDOM_ITEMS = 450;
  localparam int CALM_ITEMS   = 100;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic  carry;
    date_t d;
  } stamp_t;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  date_t  cal_now;
  stamp_t pending_stamps[$];
  int     fail_count  = 0;
  int     quiet_cycles = 0;
  bit     stalls_off  = 0;

  calendar_field_stepper u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Calendar model
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] days_in_month(logic [3:0] m, logic [6:0] y);
    case (m)
      4'd2:    return (y[1:0] == 2'b00) ? 8'd29 : 8'd28;
      4'd4,
      4'd6,
      4'd9,
      4'd11:   return 8'd30;
      default: return 8'd31;
    endcase
  endfunction

  function automatic logic [7:0] field_lo(logic [2:0] fld);
    case (fld)
      FLD_YEAR:  return YEAR_MIN;
      FLD_MONTH: return MONTH_MIN;
      FLD_DAY:   return DAY_MIN;
      FLD_HOUR:  return HOUR_MIN;
      default:   return MINUTE_MIN;
    endcase
  endfunction

  function automatic logic [7:0] field_hi(logic [2:0] fld);
    case (fld)
      FLD_YEAR:  return YEAR_MAX;
      FLD_MONTH: return MONTH_MAX;
      FLD_DAY:   return DAY_MAX;
      FLD_HOUR:  return HOUR_MAX;
      default:   return MINUTE_MAX;
    endcase
  endfunction

  function automatic logic [7:0] field_value(logic [2:0] fld);
    case (fld)
      FLD_YEAR:  return {1'b0, cal_now.year};
      FLD_MONTH: return {4'b0, cal_now.month};
      FLD_DAY:   return {3'b0, cal_now.day};
      FLD_HOUR:  return {3'b0, cal_now.hour};
      default:   return {2'b0, cal_now.minute};
    endcase
  endfunction

  function automatic void write_field(logic [2:0] fld, logic [7:0] v);
    case (fld)
      FLD_YEAR:  cal_now.year   = v[6:0];
      FLD_MONTH: cal_now.month  = v[3:0];
      FLD_DAY:   cal_now.day    = v[4:0];
      FLD_HOUR:  cal_now.hour   = v[4:0];
      default:   cal_now.minute = v[5:0];
    endcase
  endfunction

  // Step one field by one; return the wrap flag
  function automatic logic bump_field(logic [2:0] fld);
    int unsigned v;
    int unsigned lo;
    int unsigned hi;
    logic        wrapped;
    wrapped = 1'b0;
    lo = 32'(field_lo(fld));
    hi = 32'((fld == FLD_DAY) ? days_in_month(cal_now.month, cal_now.year)
                              : field_hi(fld));
    v = 32'(field_value(fld)) + 32'd1;
    if (v < lo) begin
      v = lo;
    end
    if (v > hi) begin
      v = lo;
      wrapped = 1'b1;
    end
    write_field(fld, v[7:0]);
    return wrapped;
  endfunction

  // Apply one request to the calendar and return the result it must produce
  function automatic stamp_t predict_step(logic [1:0] op, logic [2:0] sel, logic [7:0] val);
    stamp_t     s;
    logic       c;
    logic [7:0] v;
    c = 1'b0;
    case (op)
      OP_INC: begin
        if (sel <= FLD_MINUTE) c = bump_field(sel);
      end
      OP_NEW_DAY: begin
        c = bump_field(FLD_DAY);
        if (c) begin
          c = bump_field(FLD_MONTH);
          if (c) c = bump_field(FLD_YEAR);
        end
      end
      OP_LOAD: begin
        if (sel <= FLD_MINUTE) begin
          v = val;
          if (v < field_lo(sel)) v = field_lo(sel);
          if (v > field_hi(sel)) v = field_hi(sel);
          write_field(sel, v);
        end
      end
      default: ;
    endcase
    s.d     = cal_now;
    s.carry = c;
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver and result checker
  // ---------------------------------------------------------------------------

  // Send one request, with an optional idle gap before it
  task automatic send_request(logic [1:0] op, logic [2:0] sel, logic [7:0] val);
    int gap;
    if (!stalls_off && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b0, val, sel, op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_stamps.push_back(predict_step(op, sel, val));
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Compare each accepted result with the oldest pending stamp
  always @(posedge clk) begin : check_results
    stamp_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_stamps.size() == 0) begin
        $error("unexpected result: tdata %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_stamps.pop_front();
        check_field("year_out",   int'(want.d.year),   int'(m_axis_tdata[6:0]));
        check_field("month_out",  int'(want.d.month),  int'(m_axis_tdata[10:7]));
        check_field("day_out",    int'(want.d.day),    int'(m_axis_tdata[15:11]));
        check_field("hour_out",   int'(want.d.hour),   int'(m_axis_tdata[20:16]));
        check_field("minute_out", int'(want.d.minute), int'(m_axis_tdata[26:21]));
        check_field("carry_out",  int'(want.carry),    int'(m_axis_tdata[27]));
      end
    end
  end

  // Stall the result side in random bursts
  initial begin : result_stalls
    int burst;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!stalls_off && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 15);
        m_axis_tready <= 1'b0;
        repeat (burst - 1) @(negedge clk);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Observe the reset date through an ignored request
  task automatic test_reset_date();
    send_request(OP_NONE, FLD_YEAR, 8'd0);
  endtask

  // Wrap minute, hour, year and month from their maxima, then step the day
  task automatic test_field_wraps();
    send_request(OP_LOAD, FLD_MINUTE, 8'd59);
    send_request(OP_INC,  FLD_MINUTE, 8'd0);
    send_request(OP_LOAD, FLD_HOUR,   8'd23);
    send_request(OP_INC,  FLD_HOUR,   8'd0);
    send_request(OP_LOAD, FLD_YEAR,   8'd86);
    send_request(OP_INC,  FLD_YEAR,   8'd0);
    send_request(OP_LOAD, FLD_MONTH,  8'd12);
    send_request(OP_INC,  FLD_MONTH,  8'd0);
    send_request(OP_INC,  FLD_DAY,    8'd0);
  endtask

  // Leap February, then the full day-month-year chain
  task automatic test_new_day_chain();
    send_request(OP_LOAD,    FLD_YEAR,  8'd20);
    send_request(OP_LOAD,    FLD_MONTH, 8'd2);
    send_request(OP_LOAD,    FLD_DAY,   8'd28);
    send_request(OP_NEW_DAY, FLD_DAY,   8'd0);
    send_request(OP_NEW_DAY, FLD_DAY,   8'd0);
    send_request(OP_LOAD,    FLD_MONTH, 8'd12);
    send_request(OP_LOAD,    FLD_DAY,   8'd31);
    send_request(OP_LOAD,    FLD_YEAR,  8'd86);
    send_request(OP_NEW_DAY, FLD_DAY,   8'd0);
  endtask

  // Saturate loads; keep a day past the month length until the next step
  task automatic test_load_limits();
    send_request(OP_LOAD, FLD_MONTH, 8'd4);
    send_request(OP_LOAD, FLD_DAY,   8'd255);
    send_request(OP_INC,  FLD_DAY,   8'd0);
    send_request(OP_LOAD, FLD_MONTH, 8'd0);
  endtask

  // Unused selects and opcode change nothing
  task automatic test_unused_codes();
    send_request(OP_INC,  FLD_UNUSED_LAST,  8'd0);
    send_request(OP_LOAD, FLD_UNUSED_FIRST, 8'd255);
    send_request(OP_NONE, FLD_MINUTE,       8'd170);
  endtask

  // Pick a load value near one of the field's limits
  function automatic logic [7:0] near_limit(logic [2:0] fld);
    int base;
    int v;
    base = ($urandom_range(0, 1) == 0) ? int'(field_lo(fld)) : int'(field_hi(fld));
    v = base + int'($urandom_range(0, 2)) - 1;
    if (v < 0) v = 0;
    return v[7:0];
  endfunction

  // Random traffic biased toward new-day chains and edge loads
  task automatic test_random_traffic(int count);
    int         pick;
    logic [1:0] op;
    logic [2:0] sel;
    logic [7:0] val;
    for (int i = 0; i < count; i++) begin
      if (i >= count - CALM_ITEMS) stalls_off = 1'b1;
      pick = $urandom_range(0, 99);
      sel  = 3'($urandom_range(FLD_YEAR, FLD_MINUTE));
      val  = 8'($urandom_range(0, 255));
      if (pick < 35) begin
        op = OP_NEW_DAY;
      end else if (pick < 60) begin
        op = OP_INC;
      end else if (pick < 90) begin
        op = OP_LOAD;
        if ($urandom_range(0, 1) == 0) val = near_limit(sel);
      end else if (pick < 95) begin
        op = OP_NONE;
        sel = 3'($urandom_range(0, 7));
      end else begin
        op  = ($urandom_range(0, 1) == 0) ? OP_INC : OP_LOAD;
        sel = 3'($urandom_range(FLD_UNUSED_FIRST, FLD_UNUSED_LAST));
      end
      send_request(op, sel, val);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cal_now.year   = YEAR_RST;
    cal_now.month  = MONTH_RST;
    cal_now.day    = DAY_RST;
    cal_now.hour   = HOUR_RST;
    cal_now.minute = MINUTE_RST;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_date();
    test_field_wraps();
    test_new_day_chain();
    test_load_limits();
    test_unused_codes();
    test_random_traffic(RANDOM_ITEMS);

    // Drop the request and drain the results
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_stamps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
